// ===== rtl/dtc_pkg.sv =====
`timescale 1ns / 1ps

package dtc_pkg;

   // Frame geometry
   localparam int MAX_COLUMNS = 128;
   localparam int MAX_ROWS    = 64;
   localparam int CELL_COUNT  = MAX_COLUMNS * MAX_ROWS;

   localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int ADDR_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

   // Field widths
   localparam int POS_W   = 16;
   localparam int CHAR_W  = 8;
   localparam int COLOR_W = 16;
   localparam int PRIO_W  = 16;
   localparam int WIDTH_W  = 8;
   localparam int HEIGHT_W = 7;
   localparam int CSR_W    = 8;

   // Operation codes
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_DRAW  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // Register indexes
   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   // Reset values
   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 8'd80;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 7'd25;
   localparam logic [CHAR_W-1:0]   BLANK_CHAR   = 8'd32;
   localparam logic [PRIO_W-1:0]   EMPTY_PRIO   = '1;

   // One stored cell
   typedef struct packed {
      logic [CHAR_W-1:0]  character;
      logic [COLOR_W-1:0] color;
      logic [PRIO_W-1:0]  priority_val;
   } cell_type;

   localparam int CELL_W = $bits(cell_type);

   // Decoded request word
   typedef struct packed {
      logic [1:0]         op;
      logic               in_range;
      logic [ADDR_W-1:0]  addr;
      logic [CHAR_W-1:0]  character;
      logic [COLOR_W-1:0] color;
      logic [PRIO_W-1:0]  priority_val;
   } item_type;

   // Response word
   typedef struct packed {
      logic               written;
      logic               in_range;
      logic [CHAR_W-1:0]  cell_character;
      logic [COLOR_W-1:0] cell_color;
   } result_type;

   // Memory write port
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      cell_type          data;
   } mem_wr_type;

endpackage

// ===== rtl/dtc_if.sv =====
`timescale 1ns / 1ps

interface dtc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [15:0] column;
   logic [15:0] row;
   logic [7:0]  character;
   logic [15:0] color;
   logic [15:0] priority_req;

   modport source (output valid, operation, column, row, character, color, priority_req,
                   input ready);
   modport sink (input valid, operation, column, row, character, color, priority_req,
                 output ready);
endinterface

interface dtc_rsp_if;
   logic        valid;
   logic        ready;
   logic        written;
   logic        in_range;
   logic [7:0]  cell_character;
   logic [15:0] cell_color;

   modport source (output valid, written, in_range, cell_character, cell_color,
                   input ready);
   modport sink (input valid, written, in_range, cell_character, cell_color,
                 output ready);
endinterface

// ===== rtl/dtc_cell_ram.sv =====
`timescale 1ns / 1ps

module dtc_cell_ram #(
   parameter int DATA_W = 40,
   parameter int ADDR_W = 13
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rdata_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/dtc_ctrl.sv =====
`timescale 1ns / 1ps

module dtc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  dtc_pkg::item_type       req_item,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output dtc_pkg::result_type     rsp_word,
   output logic [dtc_pkg::ADDR_W-1:0] ram_raddr,
   input  dtc_pkg::cell_type       ram_rdata,
   output dtc_pkg::mem_wr_type     ram_wr
);
   import dtc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SWEEP
   } state_type;

   state_type         state_ff;
   item_type          item_ff;
   logic [ADDR_W-1:0] sweep_ff;
   logic              sweep_rsp_ff;
   logic              rsp_valid_ff;
   result_type        rsp_ff;

   logic       slot_free;
   logic       draw_ok;
   logic       finish;
   result_type result_in;
   logic       sweep_last;

   assign req_ready = (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign finish    = (state_ff == ST_CHECK) && slot_free;
   assign sweep_last = (sweep_ff == ADDR_W'(CELL_COUNT - 1));

   // Address the read at the incoming word, then hold it during the check
   assign ram_raddr = (state_ff == ST_IDLE) ? req_item.addr : item_ff.addr;

   // Depth test against the stored priority
   assign draw_ok = (item_ff.op == OP_DRAW) && item_ff.in_range
                    && (item_ff.character != '0)
                    && ($signed(ram_rdata.priority_val) <= $signed(item_ff.priority_val));

   // Build the response word
   always_comb begin
      result_in = '0;
      case (item_ff.op)
         OP_DRAW: begin
            result_in.in_range = item_ff.in_range;
            result_in.written  = draw_ok;
         end
         OP_READ: begin
            if (item_ff.in_range) begin
               result_in.in_range       = 1'b1;
               result_in.cell_character = ram_rdata.character;
               result_in.cell_color     = ram_rdata.color;
            end
         end
         default: result_in = '0;
      endcase
   end

   // Memory write: blank during the sweep, new cell on a winning draw
   always_comb begin
      ram_wr = '0;
      if (state_ff == ST_SWEEP) begin
         ram_wr.we                = 1'b1;
         ram_wr.addr              = sweep_ff;
         ram_wr.data.character    = BLANK_CHAR;
         ram_wr.data.color        = '0;
         ram_wr.data.priority_val = EMPTY_PRIO;
      end else if (finish && draw_ok) begin
         ram_wr.we                = 1'b1;
         ram_wr.addr              = item_ff.addr;
         ram_wr.data.character    = item_ff.character;
         ram_wr.data.color        = item_ff.color;
         ram_wr.data.priority_val = item_ff.priority_val;
      end
   end

   // Sequencer, held word and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         sweep_rsp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Raise the response when a check finishes, drop it once taken
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  item_ff <= req_item;
                  if (req_item.op == OP_CLEAR) begin
                     state_ff     <= ST_SWEEP;
                     sweep_ff     <= '0;
                     sweep_rsp_ff <= 1'b1;
                  end else begin
                     state_ff <= ST_CHECK;
                  end
               end
            end
            ST_CHECK: begin
               if (slot_free) begin
                  rsp_ff   <= result_in;
                  state_ff <= ST_IDLE;
               end
            end
            ST_SWEEP: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_last) begin
                  state_ff <= sweep_rsp_ff ? ST_CHECK : ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

// ===== rtl/depth_tested_text_cell_compositor.sv =====
`timescale 1ns / 1ps

// Character-cell frame store with a per-cell priority buffer, kept in one
// single-port-write, registered-read memory of MAX_COLUMNS * MAX_ROWS cells.
// A draw or read word is read from the memory as it is accepted, then
// tested for priority, written back and loaded into the response register
// once that register is free. A clear walks every cell, one per cycle,
// then sends a response. After reset the same clearing pass runs with
// req.ready low and no response; csr writes are taken at any time. Screen
// size registers above the store's size clamp to it.
module depth_tested_text_cell_compositor (
   input  logic                        clock,
   input  logic                        reset,
   dtc_req_if.sink                     req,
   dtc_rsp_if.source                   rsp,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [dtc_pkg::CSR_W-1:0]   csr_wdata
);
   import dtc_pkg::*;

   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;

   logic [POS_W-1:0]  width_ext;
   logic [POS_W-1:0]  height_ext;
   logic [POS_W-1:0]  width_eff;
   logic [POS_W-1:0]  height_eff;
   logic              on_screen;
   logic [COL_W-1:0]  col_idx;
   logic [ROW_W-1:0]  row_idx;
   item_type          item;
   result_type        rsp_word;
   cell_type          ram_rdata;
   logic [ADDR_W-1:0] ram_raddr;
   mem_wr_type        ram_wr;
   logic [CELL_W-1:0] ram_rdata_raw;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_wdata[WIDTH_W-1:0];
            CSR_HEIGHT: height_ff <= csr_wdata[HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the screen to the store and test the position
   assign width_ext  = POS_W'(width_ff);
   assign height_ext = POS_W'(height_ff);
   assign width_eff  = (width_ext > POS_W'(MAX_COLUMNS)) ? POS_W'(MAX_COLUMNS) : width_ext;
   assign height_eff = (height_ext > POS_W'(MAX_ROWS)) ? POS_W'(MAX_ROWS) : height_ext;
   assign on_screen = !req.column[POS_W-1] && (req.column < width_eff)
                      && !req.row[POS_W-1] && (req.row < height_eff);

   assign col_idx = req.column[COL_W-1:0];
   assign row_idx = req.row[ROW_W-1:0];

   // Decode the request word
   always_comb begin
      item.op           = req.operation;
      item.in_range     = on_screen;
      item.addr         = on_screen ? ADDR_W'(ADDR_W'(row_idx) * ADDR_W'(MAX_COLUMNS))
                                      + ADDR_W'(col_idx) : '0;
      item.character    = req.character;
      item.color        = req.color;
      item.priority_val = req.priority_req;
   end

   dtc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .req_item  (item),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .rsp_word  (rsp_word),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .ram_wr    (ram_wr)
   );

   dtc_cell_ram #(
      .DATA_W (CELL_W),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock (clock),
      .we    (ram_wr.we),
      .waddr (ram_wr.addr),
      .wdata (ram_wr.data),
      .raddr (ram_raddr),
      .rdata (ram_rdata_raw)
   );

   assign ram_rdata = ram_rdata_raw;

   // Drive the response channel
   assign rsp.written        = rsp_word.written;
   assign rsp.in_range       = rsp_word.in_range;
   assign rsp.cell_character = rsp_word.cell_character;
   assign rsp.cell_color     = rsp_word.cell_color;

endmodule
